// ----- rtl/raymarch_pixel_color_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ray-marched pixel color unit
// Short forms for same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef RAYMARCH_PIXEL_COLOR_UNIT_MACROS_SVH
`define RAYMARCH_PIXEL_COLOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and the palette table of the ray-marched pixel color unit.
// ----------------------------------------------------------------------------
package rpc_pkg;

   localparam int DEPTH_W = 9;
   localparam int XS_W    = 9;
   localparam int YS_W    = 8;
   localparam int OPND_W  = 8;
   localparam int PROD_W  = OPND_W + DEPTH_W;

   localparam logic [4:0] STAR_INDEX = 5'd11;

   typedef struct packed {
      logic [5:0] column;
      logic [5:0] row;
      logic [7:0] frame_count;
   } req_type;

   typedef struct packed {
      logic [3:0] screen_color;
      logic [4:0] palette_index;
      logic       is_sky;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_Y,
      ST_MUL_X,
      ST_TEST
   } state_type;

   typedef enum logic {
      MUL_SEL_Y,
      MUL_SEL_X
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type       sel;
      logic [YS_W-1:0]   ys;
      logic [OPND_W-1:0] col_dist;
      logic [DEPTH_W-1:0] depth;
   } mul_req_type;

   localparam logic [3:0] REMAP_TABLE [32] = '{
      4'd0,  4'd5,  4'd0,  4'd5,  4'd5,  4'd5,  4'd10, 4'd10,
      4'd5,  4'd5,  4'd10, 4'd10, 4'd7,  4'd7,  4'd15, 4'd15,
      4'd1,  4'd2,  4'd1,  4'd2,  4'd3,  4'd9,  4'd3,  4'd9,
      4'd13, 4'd12, 4'd13, 4'd12, 4'd4,  4'd4,  4'd4,  4'd4
   };

endpackage

// ----- rtl/rpc_mult.sv -----
// ----------------------------------------------------------------------------
// rpc_mult
// Shared multiplier: scales either the row term or the column distance by
// the current depth, with a registered product.
// ----------------------------------------------------------------------------
module rpc_mult (
   input  logic                          clock,
   input  rpc_pkg::mul_req_type          mul_req,
   output logic [rpc_pkg::PROD_W-1:0]    product
);

   logic [rpc_pkg::OPND_W-1:0] opnd_a;
   logic [rpc_pkg::PROD_W-1:0] product_in;
   logic [rpc_pkg::PROD_W-1:0] product_ff;

   always_comb begin
      case (mul_req.sel)
         rpc_pkg::MUL_SEL_Y: opnd_a = mul_req.ys;
         rpc_pkg::MUL_SEL_X: opnd_a = mul_req.col_dist;
         default:            opnd_a = mul_req.ys;
      endcase
      product_in = rpc_pkg::PROD_W'(opnd_a) * rpc_pkg::PROD_W'(mul_req.depth);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- rtl/raymarch_pixel_color_unit.sv -----
// ----------------------------------------------------------------------------
// raymarch_pixel_color_unit
// Marches one ray per pixel request and returns its palette and screen color.
// ----------------------------------------------------------------------------
// A pixel request beat is taken when start is high and busy is low; busy then
// stays high until the result is ready. The result shows on rsp_data for one
// cycle with rsp_strobe high and cannot be held off, so the receiver must
// take it in that cycle. Each depth step of the march runs on the single
// shared multiplier as row term, then column distance, then the hit test.
// A hit ends the march in the test state and a sky exit in the column
// distance state; the strobe follows in the next cycle, in which busy
// is already low and a new request can be taken. The march tries at most
// 6*column - START_DEPTH + 2 depth values, so a pixel's march is longest at
// column 39 on the 40-column screen and at column 44 over the whole field,
// and is shortest when the ray leaves at once.
// ----------------------------------------------------------------------------
`include "raymarch_pixel_color_unit_macros.svh"

module raymarch_pixel_color_unit #(
   parameter int START_DEPTH = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rpc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rpc_pkg::rsp_type rsp_data
);

   // Sequencer state and the per-pixel working registers.
   rpc_pkg::state_type                state_ff, state_in;
   logic [rpc_pkg::XS_W-1:0]          xs_ff, xs_in;
   logic [rpc_pkg::YS_W-1:0]          ys_ff, ys_in;
   logic [7:0]                        frame_ff, frame_in;
   logic [rpc_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic [rpc_pkg::PROD_W-1:0]        yp_ff, yp_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   rpc_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   rpc_pkg::mul_req_type              mul_req;
   logic [rpc_pkg::PROD_W-1:0]        product;

   // Combinational helpers for the step tests.
   logic [rpc_pkg::XS_W-1:0]          col_dist;
   logic [7:0]                        star_sum;
   logic [rpc_pkg::PROD_W-1:0]        geom_or;
   logic [7:0]                        depth_frame;
   logic [7:0]                        geom_c;
   logic [4:0]                        index;

   rpc_mult u_mult (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   always_comb begin
      state_in      = state_ff;
      xs_in         = xs_ff;
      ys_in         = ys_ff;
      frame_in      = frame_ff;
      depth_in      = depth_ff;
      yp_in         = yp_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      // The column distance 6*column - depth, kept to nine bits; its top bit
      // says the ray has passed the curve and gone into the sky.
      col_dist    = xs_ff - depth_ff;
      // In the distance cycle the multiplier output holds the row term.
      star_sum    = xs_ff[7:0] + product[7:0];
      // In the test cycle the multiplier output holds the distance term.
      geom_or     = product | yp_ff;
      depth_frame = depth_ff[7:0] + frame_ff;
      geom_c      = geom_or[15:8] & depth_frame;
      index       = 5'd0;

      mul_req.sel      = rpc_pkg::MUL_SEL_Y;
      mul_req.ys       = ys_ff;
      mul_req.col_dist = col_dist[7:0];
      mul_req.depth    = depth_ff;

      case (state_ff)
         rpc_pkg::ST_IDLE: begin
            if (start) begin
               xs_in    = rpc_pkg::XS_W'({1'b0, req_data.column, 2'b00})
                        + rpc_pkg::XS_W'({2'b00, req_data.column, 1'b0});
               ys_in    = {req_data.row, 2'b00};
               frame_in = req_data.frame_count;
               depth_in = rpc_pkg::DEPTH_W'(START_DEPTH);
               state_in = rpc_pkg::ST_MUL_Y;
            end
         end
         rpc_pkg::ST_MUL_Y: begin
            // Row term 4*row*depth goes into the multiplier.
            mul_req.sel = rpc_pkg::MUL_SEL_Y;
            state_in    = rpc_pkg::ST_MUL_X;
         end
         rpc_pkg::ST_MUL_X: begin
            yp_in = product;
            if (col_dist[8]) begin
               // Sky: a star where the low byte of the sum is zero, else a
               // gradient taken from the row.
               if (star_sum == 8'd0) begin
                  index = rpc_pkg::STAR_INDEX;
               end else begin
                  index = {1'b1, ys_ff[7:4]};
               end
               rsp_data_in.palette_index = index;
               rsp_data_in.screen_color  = rpc_pkg::REMAP_TABLE[index];
               rsp_data_in.is_sky        = 1'b1;
               rsp_strobe_in             = 1'b1;
               state_in                  = rpc_pkg::ST_IDLE;
            end else begin
               mul_req.sel = rpc_pkg::MUL_SEL_X;
               state_in    = rpc_pkg::ST_TEST;
            end
         end
         rpc_pkg::ST_TEST: begin
            depth_in = depth_ff + rpc_pkg::DEPTH_W'(1);
            if (geom_c[4]) begin
               // Hit: the index is c - 16, and with bit 4 set that leaves
               // only the low four bits.
               index                     = 5'(geom_c - 8'd16);
               rsp_data_in.palette_index = index;
               rsp_data_in.screen_color  = rpc_pkg::REMAP_TABLE[index];
               rsp_data_in.is_sky        = 1'b0;
               rsp_strobe_in             = 1'b1;
               state_in                  = rpc_pkg::ST_IDLE;
            end else begin
               state_in = rpc_pkg::ST_MUL_Y;
            end
         end
         default: begin
            state_in = rpc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state is reset; the working values are loaded on each request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rpc_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
      frame_ff    <= frame_in;
      depth_ff    <= depth_in;
      yp_ff       <= yp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != rpc_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // An accepted request always starts a march.
   `RPC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result only appears once the march is over and came from a busy cycle.
   `RPC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy && $past(busy))
   // A hit leaves an index below sixteen.
   `RPC_ASSERT_NOW(a_hit_index, clock, reset, rsp_strobe && !rsp_data.is_sky,
      rsp_data.palette_index[4] == 1'b0)
   // A sky pixel is either a star or in the upper half of the palette.
   `RPC_ASSERT_NOW(a_sky_index, clock, reset, rsp_strobe && rsp_data.is_sky,
      (rsp_data.palette_index == rpc_pkg::STAR_INDEX) || rsp_data.palette_index[4])

endmodule
